/* rtl/core/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared constants, types and the sequencer program for the escape-time core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

  // field widths
  localparam int IN_W       = 29;
  localparam int OUT_W      = 16;
  localparam int Z_W        = 32;
  localparam int LIMIT_W    = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // default parameter values
  localparam int FRAC_BITS_DEF  = 26;
  localparam int COUNT_BITS_DEF = 16;

  // register map (index is byte address / 4)
  localparam logic [CFG_ADDR_W-3:0] REG_ITER_LIMIT = '0;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST      = 16'd255;

  // multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_START,
    COND_LIMIT,
    COND_ESC,
    COND_PUSH
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_SQR  = 3'd1;
  localparam step_t STEP_SQI  = 3'd2;
  localparam step_t STEP_CRS  = 3'd3;
  localparam step_t STEP_UPD  = 3'd4;
  localparam step_t STEP_DONE = 3'd5;

  // one control word of the program
  typedef struct packed {
    mul_op_t mul_op;
    logic    load;
    logic    update;
    logic    push;
    cond_t   cond;
    step_t   jmp;
    step_t   nxt;
  } ctrl_word_t;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    update;
  } dp_ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic esc;
    logic lim_hit;
  } dp_stat_t;

  // sequencer program: one word per step
  function automatic ctrl_word_t ucode_word(input step_t step);
    ctrl_word_t cw;
    cw = '{mul_op: MUL_NONE, load: 1'b0, update: 1'b0, push: 1'b0,
           cond: COND_ALWAYS, jmp: STEP_IDLE, nxt: STEP_IDLE};
    unique case (step)
      // wait for a point, clear the orbit
      STEP_IDLE: begin
        cw.load = 1'b1;
        cw.cond = COND_START;
        cw.jmp  = STEP_SQR;
        cw.nxt  = STEP_IDLE;
      end
      // zr*zr, leave when the count reached the limit
      STEP_SQR: begin
        cw.mul_op = MUL_RR;
        cw.cond   = COND_LIMIT;
        cw.jmp    = STEP_DONE;
        cw.nxt    = STEP_SQI;
      end
      // zi*zi
      STEP_SQI: begin
        cw.mul_op = MUL_II;
        cw.cond   = COND_NEVER;
        cw.nxt    = STEP_CRS;
      end
      // zr*zi, leave when |z|^2 > 4
      STEP_CRS: begin
        cw.mul_op = MUL_RI;
        cw.cond   = COND_ESC;
        cw.jmp    = STEP_DONE;
        cw.nxt    = STEP_UPD;
      end
      // z <= z*z + c, count up
      STEP_UPD: begin
        cw.update = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.jmp    = STEP_SQR;
        cw.nxt    = STEP_SQR;
      end
      // hand the count to the output register
      STEP_DONE: begin
        cw.push = 1'b1;
        cw.cond = COND_PUSH;
        cw.jmp  = STEP_IDLE;
        cw.nxt  = STEP_DONE;
      end
      default: begin
        cw.cond = COND_ALWAYS;
        cw.jmp  = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

/* rtl/core/mbe_in_if.sv */
// ----------------------------------------------------------------------------
// mbe_in_if
// Point channel: valid/ready handshake carrying c in fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbe_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mbe_pkg::IN_W-1:0]  c_real;
  logic signed [mbe_pkg::IN_W-1:0]  c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

/* rtl/core/mbe_out_if.sv */
// ----------------------------------------------------------------------------
// mbe_out_if
// Result channel: valid/ready handshake carrying the escape count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbe_out_if;
  logic                      valid;
  logic                      ready;
  logic [mbe_pkg::OUT_W-1:0] escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink   (input valid, input escape_count, output ready);
endinterface

/* rtl/core/mbe_datapath.sv */
// ----------------------------------------------------------------------------
// mbe_datapath
// Orbit registers, one shared 32x32 multiplier, update adders and counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_datapath #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  mbe_pkg::dp_ctrl_t                 ctrl,
  input  logic signed [mbe_pkg::IN_W-1:0]   c_real,
  input  logic signed [mbe_pkg::IN_W-1:0]   c_imag,
  input  logic [mbe_pkg::LIMIT_W-1:0]       limit,
  output mbe_pkg::dp_stat_t                 stat,
  output logic [mbe_pkg::OUT_W-1:0]         count
);

  localparam int ZW     = mbe_pkg::Z_W;
  localparam int PW     = 2 * ZW;
  localparam int SW     = PW + 2;
  localparam int CW     = (COUNT_BITS > mbe_pkg::LIMIT_W) ? COUNT_BITS : mbe_pkg::LIMIT_W;
  localparam int THR_SH = 2 * FRAC_BITS + 2;
  localparam bit ESC_ON = (THR_SH < PW);
  localparam logic [PW-1:0] ESC_THR = ESC_ON ? (PW'(1) << THR_SH) : '0;
  localparam logic [CW-1:0] CNT_MAX = CW'({COUNT_BITS{1'b1}});
  localparam logic signed [SW-1:0] Z_MAX = SW'({1'b0, {(ZW-1){1'b1}}});
  localparam logic signed [SW-1:0] Z_MIN = -SW'({1'b0, {(ZW-1){1'b1}}}) - SW'(1);

  // clamp a wide sum into the orbit range
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] x);
    logic signed [ZW-1:0] r;
    if (x > Z_MAX) begin
      r = {1'b0, {(ZW-1){1'b1}}};
    end else if (x < Z_MIN) begin
      r = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      r = x[ZW-1:0];
    end
    return r;
  endfunction

  logic signed [mbe_pkg::IN_W-1:0] c_real_r, c_imag_r;
  logic signed [ZW-1:0]            z_real_r, z_imag_r;
  logic signed [ZW-1:0]            z_real_nxt, z_imag_nxt;
  logic signed [PW-1:0]            sq_r_r, sq_i_r, cross_r;
  logic [COUNT_BITS-1:0]           n_r;
  logic signed [ZW-1:0]            mul_a, mul_b;
  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            sr, si, cr;
  logic signed [SW-1:0]            sum_r, sum_i;
  logic [PW-1:0]                   mag;
  logic [CW-1:0]                   lim_eff, n_ext;

  // shared multiplier operand select
  always_comb begin
    mul_a = (ctrl.mul_op == mbe_pkg::MUL_II) ? z_imag_r : z_real_r;
    mul_b = (ctrl.mul_op == mbe_pkg::MUL_RR) ? z_real_r : z_imag_r;
    prod  = mul_a * mul_b;
  end

  // floor shifts back to the fixed-point grid, then add c and saturate
  always_comb begin
    sr         = sq_r_r >>> FRAC_BITS;
    si         = sq_i_r >>> FRAC_BITS;
    cr         = cross_r >>> (FRAC_BITS - 1);
    sum_r      = SW'(sr) - SW'(si) + SW'(c_real_r);
    sum_i      = SW'(cr) + SW'(c_imag_r);
    z_real_nxt = sat_z(sum_r);
    z_imag_nxt = sat_z(sum_i);
  end

  // escape test on the exact squares
  assign mag      = $unsigned(sq_r_r) + $unsigned(sq_i_r);
  assign stat.esc = ESC_ON && (mag > ESC_THR);

  // limit clamped to the counter range
  assign lim_eff      = (CW'(limit) < CNT_MAX) ? CW'(limit) : CNT_MAX;
  assign n_ext        = CW'(n_r);
  assign stat.lim_hit = (n_ext >= lim_eff);
  assign count        = n_ext[mbe_pkg::OUT_W-1:0];

  // orbit, products and count
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_real_r <= c_real;
      c_imag_r <= c_imag;
      z_real_r <= '0;
      z_imag_r <= '0;
      n_r      <= '0;
    end else if (ctrl.update) begin
      z_real_r <= z_real_nxt;
      z_imag_r <= z_imag_nxt;
      n_r      <= COUNT_BITS'(n_r + 1'b1);
    end
    case (ctrl.mul_op)
      mbe_pkg::MUL_RR: sq_r_r  <= prod;
      mbe_pkg::MUL_II: sq_i_r  <= prod;
      mbe_pkg::MUL_RI: cross_r <= prod;
      default: ;
    endcase
  end

endmodule

/* rtl/core/mandelbrot_escape_time.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one complex point, run by a small microcoded program.
//
//   channel | dir | handshake          | payload
//   in_ch   | in  | valid/ready        | c_real, c_imag (signed Q3.26, 29 b)
//   out_ch  | out | valid/ready        | escape_count (16 b)
//   cfg_*   | in  | APB write, pready=1| iteration_limit at byte address 0
//
// Each iteration runs three products on the shared 32x32 multiplier and
// one update step.
// One point is in work at a time; the next is taken once the count sits in
// the output register, which holds it until the sink takes it.
// Synchronous active-low reset returns to idle with the limit at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = mbe_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mbe_in_if.sink                             in_ch,
  mbe_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW = mbe_pkg::CFG_ADDR_W;

  mbe_pkg::step_t              pc_r, pc_nxt;
  mbe_pkg::ctrl_word_t         cw;
  mbe_pkg::dp_ctrl_t           dp_ctrl;
  mbe_pkg::dp_stat_t           dp_stat;
  logic [mbe_pkg::LIMIT_W-1:0] limit_r;
  logic                        out_valid_r;
  logic [mbe_pkg::OUT_W-1:0]   out_count_r;
  logic [mbe_pkg::OUT_W-1:0]   count;
  logic                        accept, push, take, cfg_wr, reg_hit;

  // config port
  assign reg_hit    = (cfg_paddr[AW-1:2] == mbe_pkg::REG_ITER_LIMIT);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? mbe_pkg::CFG_DATA_W'(limit_r) : '0;

  // fetch the control word of the current step
  assign cw     = mbe_pkg::ucode_word(pc_r);
  assign accept = cw.load && in_ch.valid;
  assign push   = cw.push && (!out_valid_r || out_ch.ready);

  // jump condition
  always_comb begin
    unique case (cw.cond)
      mbe_pkg::COND_NEVER:  take = 1'b0;
      mbe_pkg::COND_ALWAYS: take = 1'b1;
      mbe_pkg::COND_START:  take = accept;
      mbe_pkg::COND_LIMIT:  take = dp_stat.lim_hit;
      mbe_pkg::COND_ESC:    take = dp_stat.esc;
      mbe_pkg::COND_PUSH:   take = push;
      default:              take = 1'b0;
    endcase
    pc_nxt = take ? cw.jmp : cw.nxt;
  end

  // datapath controls
  assign dp_ctrl.load   = accept;
  assign dp_ctrl.mul_op = cw.mul_op;
  assign dp_ctrl.update = cw.update;

  // handshakes
  assign in_ch.ready         = cw.load;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.escape_count = out_count_r;

  // step counter, output register and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= mbe_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= mbe_pkg::LIMIT_RST;
    end else begin
      pc_r <= pc_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
        out_count_r <= count;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        limit_r <= cfg_pwdata[mbe_pkg::LIMIT_W-1:0];
      end
    end
  end

  mbe_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .ctrl   (dp_ctrl),
    .c_real (in_ch.c_real),
    .c_imag (in_ch.c_imag),
    .limit  (limit_r),
    .stat   (dp_stat),
    .count  (count)
  );

endmodule
